[hdl/dbdn_pkg.sv]
// shared types, constants and helpers of the detection box decoder with nms
package dbdn_pkg;

  localparam int MAX_CANDIDATES = 64;
  localparam int MAX_GRID_UNITS = 64;

  localparam int UNIT_W   = $clog2(MAX_GRID_UNITS + 1);
  localparam int CELL_W   = $clog2(4 * MAX_GRID_UNITS);
  localparam int GRID_W   = CELL_W + 1;
  localparam int COUNT_W  = $clog2(MAX_CANDIDATES + 1);
  localparam int ROW_W    = 17;
  localparam int EXPECT_W = 2 * UNIT_W + ROW_W;
  localparam int AX_W     = CELL_W + 18;
  localparam int CX_W     = AX_W + 17;
  localparam int EW_W     = 45;
  localparam int HW_W     = EW_W - 2;
  localparam int EDGE_W   = CX_W + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [ROW_W-1:0] ROW_MAX = '1;
  localparam int ROWS_PER_UNIT = 21;
  localparam int DEC_STAGES    = 6;
  localparam int NMS_LAT       = 3;
  localparam int CNT_W         = $clog2(DEC_STAGES);

  localparam logic signed [33:0] LOG2E_Q16 = 34'sd94548;
  localparam logic signed [33:0] EXP_BIAS  = 34'sd4294967296;
  localparam logic [39:0]        LN2_Q16   = 40'd45426;

  localparam logic [16:0] POW2_FRAC [16] = '{
    17'd65536, 17'd68438, 17'd71468, 17'd74632, 17'd77936, 17'd81386, 17'd84990, 17'd88752,
    17'd92682, 17'd96785, 17'd101070, 17'd105545, 17'd110218, 17'd115098, 17'd120194,
    17'd125515
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_W, REG_GRID_H, REG_INV_SCALE, REG_IMAGE_W, REG_IMAGE_H,
    REG_SCORE_THR, REG_NMS_THR
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_DET      = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {OP_HOLD, OP_INSERT, OP_SHIFT, OP_CLEAR} cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_INSERT, ST_CHECK, ST_HEAD, ST_CMP, ST_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] score;
  } box_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_go;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] log_width;
    logic signed [15:0] log_height;
    logic [15:0]        objectness;
    logic [15:0]        class_prob;
  } row_t;

  // clamp an edge at 22 fraction bits to [0, lim] and round to q12.4
  function automatic logic [15:0] clamp_edge(input logic signed [EDGE_W-1:0] v,
                                             input logic [11:0] lim);
    logic signed [EDGE_W-1:0] hi;
    logic [33:0] c;
    logic [33:0] rnd;
    hi = $signed(EDGE_W'({lim, 22'b0}));
    if (v < 0) c = '0;
    else if (v > hi) c = {lim, 22'b0};
    else c = v[33:0];
    rnd = c + 34'd131072;
    return rnd[33:18];
  endfunction

endpackage

[hdl/dbdn_decode.sv]
// decode pipeline: score, exp table, scaling and edge clamping of one row
module dbdn_decode (
  input  logic                  clk,
  input  logic                  load,
  input  dbdn_pkg::row_t        row,
  input  logic [1:0]            level,
  input  logic [dbdn_pkg::CELL_W-1:0] cell_x,
  input  logic [dbdn_pkg::CELL_W-1:0] cell_y,
  input  logic [15:0]           inv_scale,
  input  logic [11:0]           image_width,
  input  logic [11:0]           image_height,
  input  logic [16:0]           score_threshold,
  output dbdn_pkg::box_t        box,
  output logic                  keep
);

  dbdn_pkg::row_t                  row_r;
  logic [1:0]                      lvl_r;
  logic [dbdn_pkg::CELL_W-1:0]     cx_cell, cy_cell;

  logic [31:0]                     prod1;
  logic signed [dbdn_pkg::AX_W-1:0] ax1, ay1;
  logic [32:0]                     ux1, uy1;

  logic                            keep2;
  logic [15:0]                     score2;
  logic signed [dbdn_pkg::CX_W-1:0] cx2, cy2;
  logic [11:0]                     tx2, ty2;

  logic [23:0]                     ttx3, tty3;
  logic [17:0]                     mx4, my4;
  logic [dbdn_pkg::EW_W-1:0]       ewx5, ewy5;

  logic [15:0]                     l6, t6, r6, b6;

  logic signed [dbdn_pkg::AX_W-1:0] sx, sy, ax, ay;
  logic signed [33:0]              ux, uy;
  logic [39:0]                     tpx, tpy;
  logic [16:0]                     polyx, polyy;
  logic [33:0]                     mpx, mpy;
  logic [28:0]                     ex, ey;
  logic [dbdn_pkg::HW_W-1:0]       hwx, hwy;
  logic signed [dbdn_pkg::EDGE_W-1:0] lft, rgt, upp, low;

  always_ff @(posedge clk) begin
    if (load) begin
      row_r   <= row;
      lvl_r   <= level;
      cx_cell <= cell_x;
      cy_cell <= cell_y;
    end
  end

  // stage 1: score product, center offsets in strides, exp argument
  always_comb begin
    sx = dbdn_pkg::AX_W'(row_r.offset_x) + $signed(dbdn_pkg::AX_W'({cx_cell, 10'b0}));
    sy = dbdn_pkg::AX_W'(row_r.offset_y) + $signed(dbdn_pkg::AX_W'({cy_cell, 10'b0}));
    unique case (lvl_r)
      2'd0:    begin ax = sx <<< 3; ay = sy <<< 3; end
      2'd1:    begin ax = sx <<< 4; ay = sy <<< 4; end
      default: begin ax = sx <<< 5; ay = sy <<< 5; end
    endcase
    ux = 34'(row_r.log_width) * dbdn_pkg::LOG2E_Q16 + dbdn_pkg::EXP_BIAS;
    uy = 34'(row_r.log_height) * dbdn_pkg::LOG2E_Q16 + dbdn_pkg::EXP_BIAS;
  end

  always_ff @(posedge clk) begin
    prod1 <= row_r.objectness * row_r.class_prob;
    ax1   <= ax;
    ay1   <= ay;
    ux1   <= ux[32:0];
    uy1   <= uy[32:0];
  end

  // stage 2: threshold, rounded score, centers scaled, fractional exp term
  always_comb begin
    tpx = 40'(ux1[23:0]) * dbdn_pkg::LN2_Q16;
    tpy = 40'(uy1[23:0]) * dbdn_pkg::LN2_Q16;
  end

  always_ff @(posedge clk) begin
    keep2  <= {1'b0, prod1} >= {score_threshold, 16'b0};
    score2 <= 16'((33'(prod1) + 33'd32768) >> 16);
    cx2    <= ax1 * $signed({1'b0, inv_scale});
    cy2    <= ay1 * $signed({1'b0, inv_scale});
    tx2    <= tpx[39:28];
    ty2    <= tpy[39:28];
  end

  // stage 3: square term of the polynomial
  always_ff @(posedge clk) begin
    ttx3 <= tx2 * tx2;
    tty3 <= ty2 * ty2;
  end

  // stage 4: polynomial times table entry
  always_comb begin
    polyx = 17'd65536 + 17'(tx2) + 17'(ttx3[23:17]);
    polyy = 17'd65536 + 17'(ty2) + 17'(tty3[23:17]);
    mpx   = 34'(dbdn_pkg::POW2_FRAC[ux1[27:24]]) * 34'(polyx);
    mpy   = 34'(dbdn_pkg::POW2_FRAC[uy1[27:24]]) * 34'(polyy);
  end

  always_ff @(posedge clk) begin
    mx4 <= mpx[33:16];
    my4 <= mpy[33:16];
  end

  // stage 5: integer exponent shift, then scale
  always_comb begin
    if (ux1[32:28] >= 5'd16) ex = 29'(mx4) << (ux1[32:28] - 5'd16);
    else ex = 29'(mx4 >> (5'd16 - ux1[32:28]));
    if (uy1[32:28] >= 5'd16) ey = 29'(my4) << (uy1[32:28] - 5'd16);
    else ey = 29'(my4 >> (5'd16 - uy1[32:28]));
  end

  always_ff @(posedge clk) begin
    ewx5 <= dbdn_pkg::EW_W'(ex) * dbdn_pkg::EW_W'(inv_scale);
    ewy5 <= dbdn_pkg::EW_W'(ey) * dbdn_pkg::EW_W'(inv_scale);
  end

  // stage 6: half sizes, edges, clamp and round
  always_comb begin
    hwx = dbdn_pkg::HW_W'(ewx5 >> (3'd4 - 3'(lvl_r)));
    hwy = dbdn_pkg::HW_W'(ewy5 >> (3'd4 - 3'(lvl_r)));
    lft = dbdn_pkg::EDGE_W'(cx2) - $signed(dbdn_pkg::EDGE_W'(hwx));
    rgt = dbdn_pkg::EDGE_W'(cx2) + $signed(dbdn_pkg::EDGE_W'(hwx));
    upp = dbdn_pkg::EDGE_W'(cy2) - $signed(dbdn_pkg::EDGE_W'(hwy));
    low = dbdn_pkg::EDGE_W'(cy2) + $signed(dbdn_pkg::EDGE_W'(hwy));
  end

  always_ff @(posedge clk) begin
    l6 <= dbdn_pkg::clamp_edge(lft, image_width);
    r6 <= dbdn_pkg::clamp_edge(rgt, image_width);
    t6 <= dbdn_pkg::clamp_edge(upp, image_height);
    b6 <= dbdn_pkg::clamp_edge(low, image_height);
  end

  assign box  = '{left: l6, top: t6, right: r6, bottom: b6, score: score2};
  assign keep = (lvl_r != 2'd3) && keep2 && (r6 > l6) && (b6 > t6);

endmodule

[hdl/dbdn_cell.sv]
// one slot of the score-sorted candidate chain with its overlap test
module dbdn_cell (
  input  logic                clk,
  input  logic                rst,
  input  dbdn_pkg::cell_ctl_t ctl,
  input  logic                cmp_en,
  input  dbdn_pkg::box_t      new_box,
  input  dbdn_pkg::box_t      prev_box,
  input  logic                prev_valid,
  input  logic                prev_ge,
  input  dbdn_pkg::box_t      next_box,
  input  logic                next_valid,
  input  logic                next_supp,
  input  dbdn_pkg::box_t      head_box,
  input  logic [31:0]         head_area,
  input  logic [16:0]         nms_thr,
  output dbdn_pkg::box_t      box,
  output logic                valid,
  output logic                supp,
  output logic                ge,
  output logic [31:0]         area
);

  logic        ga, gb, gc;
  logic [31:0] inter_a, inter_b, inter_c;
  logic [32:0] uni_b;
  logic [33:0] hi_c;
  logic [32:0] lo_c;
  logic [15:0] il, it, ir, ib, iw, ih;
  logic        over;

  assign ge = valid && (box.score >= new_box.score);

  always_comb begin
    il = (box.left > head_box.left) ? box.left : head_box.left;
    it = (box.top > head_box.top) ? box.top : head_box.top;
    ir = (box.right < head_box.right) ? box.right : head_box.right;
    ib = (box.bottom < head_box.bottom) ? box.bottom : head_box.bottom;
    iw = (ir > il) ? ir - il : 16'd0;
    ih = (ib > it) ? ib - it : 16'd0;
    over = {3'b0, inter_c, 16'b0} > ((51'(hi_c) << 16) + 51'(lo_c));
  end

  // overlap pipeline: intersection and area, union, threshold products
  always_ff @(posedge clk) begin
    inter_a <= iw * ih;
    area    <= (box.right - box.left) * (box.bottom - box.top);
    uni_b   <= 33'(head_area) + 33'(area) - 33'(inter_a);
    inter_b <= inter_a;
    hi_c    <= nms_thr * uni_b[32:16];
    lo_c    <= nms_thr * uni_b[15:0];
    inter_c <= inter_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ga <= 1'b0;
      gb <= 1'b0;
      gc <= 1'b0;
    end else begin
      ga <= ctl.cmp_go;
      gb <= ga;
      gc <= gb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      supp  <= 1'b0;
    end else begin
      unique case (ctl.op)
        dbdn_pkg::OP_INSERT: begin
          if (!ge) valid <= prev_ge ? 1'b1 : prev_valid;
        end
        dbdn_pkg::OP_SHIFT: begin
          valid <= next_valid;
          supp  <= next_supp;
        end
        dbdn_pkg::OP_CLEAR: begin
          valid <= 1'b0;
          supp  <= 1'b0;
        end
        default: begin
          if (gc && cmp_en && valid && over) supp <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      dbdn_pkg::OP_INSERT: begin
        if (!ge) box <= prev_ge ? new_box : prev_box;
      end
      dbdn_pkg::OP_SHIFT: box <= next_box;
      default: ;
    endcase
  end

endmodule

[hdl/detection_box_decode_nms.sv]
// top level: row intake, decode pipeline, candidate chain and nms sequencer
//
// rows come in on the row channel (row_valid / row_stall) in grid order,
// stride 8 then 16 then 32; the block tracks level and cell by itself.
// one row is taken at a time: once a request is accepted, row_stall stays high
// while the row passes the 6 decode stages and the insert state, then drops again.
// the decode pipeline sets the row spacing; insertion into the sorted chain of
// 64 cells is done by all cells in parallel in the insert state.
// the row marked last_row starts the frame end: the chain head is compared
// against every other cell in parallel, a suppressed head is shifted out with
// no compare, and kept boxes leave on the box channel (box_valid / box_stall) in
// falling score order, final_result on the last one. a count mismatch or an
// empty frame gives one record with status set and zero fields.
// the result sits in an output register; a stalled result holds its fields and
// the sequencer simply waits for the register to free up.
// configuration is a plain write port (cfg_write, cfg_index, cfg_data).
// synchronous reset returns the registers to their defaults and empties the
// chain and frame counters; no clearing pass is needed.
module detection_box_decode_nms (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [dbdn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbdn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             row_valid,
  output logic                             row_stall,
  input  logic signed [15:0]               offset_x,
  input  logic signed [15:0]               offset_y,
  input  logic signed [15:0]               log_width,
  input  logic signed [15:0]               log_height,
  input  logic [15:0]                      objectness,
  input  logic [15:0]                      class_prob,
  input  logic                             last_row,
  output logic                             box_valid,
  input  logic                             box_stall,
  output logic [15:0]                      box_x1,
  output logic [15:0]                      box_y1,
  output logic [15:0]                      box_width,
  output logic [15:0]                      box_height,
  output logic [15:0]                      box_score,
  output logic                             final_result,
  output logic [1:0]                       status
);

  localparam int N = dbdn_pkg::MAX_CANDIDATES;

  // configuration registers, raw as written
  logic [6:0]  grid_width_units, grid_height_units;
  logic [15:0] inv_scale;
  logic [11:0] image_width, image_height;
  logic [16:0] score_threshold, nms_overlap_threshold;

  // effective values
  logic [dbdn_pkg::UNIT_W-1:0] uw, uh;
  logic [15:0] inv_eff;
  logic [11:0] imw, imh;

  // frame walk
  dbdn_pkg::state_t             state, state_next;
  logic [dbdn_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]                   level;
  logic [dbdn_pkg::CELL_W-1:0]  cell_x, cell_y;
  logic [dbdn_pkg::ROW_W-1:0]   row_count;
  logic [dbdn_pkg::COUNT_W-1:0] cand_count;
  logic                         last_r;
  logic [dbdn_pkg::GRID_W-1:0]  gw, gh;
  logic [dbdn_pkg::EXPECT_W-1:0] expected;
  logic                         mismatch;

  logic                         accept, frame_clear, out_free, out_load, do_insert;
  dbdn_pkg::status_t            out_status;
  logic                         out_final;
  dbdn_pkg::cell_ctl_t          ctl;
  dbdn_pkg::row_t               row_in;

  dbdn_pkg::box_t               dec_box;
  logic                         dec_keep;

  // chain wiring
  dbdn_pkg::box_t               cell_box [N];
  dbdn_pkg::box_t               prv_box [N];
  dbdn_pkg::box_t               nxt_box [N];
  logic [N-1:0]                 cell_valid, cell_supp, cell_ge;
  logic [N-1:0]                 prv_valid, prv_ge, nxt_valid, nxt_supp, live;
  logic [31:0]                  cell_area [N];
  logic                         final_box;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width_units      <= 7'd20;
      grid_height_units     <= 7'd20;
      inv_scale             <= 16'd4096;
      image_width           <= 12'd640;
      image_height          <= 12'd640;
      score_threshold       <= 17'd32768;
      nms_overlap_threshold <= 17'd29491;
    end else if (cfg_write) begin
      unique case (dbdn_pkg::cfg_reg_t'(cfg_index))
        dbdn_pkg::REG_GRID_W:    grid_width_units      <= cfg_data[6:0];
        dbdn_pkg::REG_GRID_H:    grid_height_units     <= cfg_data[6:0];
        dbdn_pkg::REG_INV_SCALE: inv_scale             <= cfg_data[15:0];
        dbdn_pkg::REG_IMAGE_W:   image_width           <= cfg_data[11:0];
        dbdn_pkg::REG_IMAGE_H:   image_height          <= cfg_data[11:0];
        dbdn_pkg::REG_SCORE_THR: score_threshold       <= cfg_data;
        dbdn_pkg::REG_NMS_THR:   nms_overlap_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero units count as one, large ones saturate at the grid limit
  always_comb begin
    if (grid_width_units == 7'd0) uw = dbdn_pkg::UNIT_W'(1);
    else if (int'(grid_width_units) > dbdn_pkg::MAX_GRID_UNITS)
      uw = dbdn_pkg::UNIT_W'(dbdn_pkg::MAX_GRID_UNITS);
    else uw = dbdn_pkg::UNIT_W'(grid_width_units);
    if (grid_height_units == 7'd0) uh = dbdn_pkg::UNIT_W'(1);
    else if (int'(grid_height_units) > dbdn_pkg::MAX_GRID_UNITS)
      uh = dbdn_pkg::UNIT_W'(dbdn_pkg::MAX_GRID_UNITS);
    else uh = dbdn_pkg::UNIT_W'(grid_height_units);
    inv_eff = (inv_scale == 16'd0) ? 16'd1 : inv_scale;
    imw     = (image_width == 12'd0) ? 12'd1 : image_width;
    imh     = (image_height == 12'd0) ? 12'd1 : image_height;
  end

  // grid size of the current level: 4x, 2x, 1x the unit count
  always_comb begin
    unique case (level)
      2'd0:    begin gw = dbdn_pkg::GRID_W'(uw) << 2; gh = dbdn_pkg::GRID_W'(uh) << 2; end
      2'd1:    begin gw = dbdn_pkg::GRID_W'(uw) << 1; gh = dbdn_pkg::GRID_W'(uh) << 1; end
      default: begin gw = dbdn_pkg::GRID_W'(uw);      gh = dbdn_pkg::GRID_W'(uh);      end
    endcase
    expected = dbdn_pkg::EXPECT_W'(uw * uh) * dbdn_pkg::EXPECT_W'(dbdn_pkg::ROWS_PER_UNIT);
    mismatch = dbdn_pkg::EXPECT_W'(row_count) != expected;
  end

  assign accept   = row_valid && !row_stall;
  assign out_free = !box_valid || !box_stall;
  assign row_in   = '{offset_x: offset_x, offset_y: offset_y, log_width: log_width,
                      log_height: log_height, objectness: objectness,
                      class_prob: class_prob};

  // ---------------------------------------------------------------- decode
  dbdn_decode u_decode (
    .clk             (clk),
    .load            (accept),
    .row             (row_in),
    .level           (level),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .inv_scale       (inv_eff),
    .image_width     (imw),
    .image_height    (imh),
    .score_threshold (score_threshold),
    .box             (dec_box),
    .keep            (dec_keep)
  );

  // ---------------------------------------------------------------- chain
  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign prv_box[j]   = dec_box;
      assign prv_valid[j] = 1'b0;
      assign prv_ge[j]    = 1'b1;
      assign live[j]      = 1'b0;
    end else begin : g_body
      assign prv_box[j]   = cell_box[j-1];
      assign prv_valid[j] = cell_valid[j-1];
      assign prv_ge[j]    = cell_ge[j-1];
      assign live[j]      = cell_valid[j] && !cell_supp[j];
    end
    if (j == N - 1) begin : g_tail
      assign nxt_box[j]   = cell_box[j];
      assign nxt_valid[j] = 1'b0;
      assign nxt_supp[j]  = 1'b0;
    end else begin : g_link
      assign nxt_box[j]   = cell_box[j+1];
      assign nxt_valid[j] = cell_valid[j+1];
      assign nxt_supp[j]  = cell_supp[j+1];
    end

    dbdn_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmp_en     (j != 0),
      .new_box    (dec_box),
      .prev_box   (prv_box[j]),
      .prev_valid (prv_valid[j]),
      .prev_ge    (prv_ge[j]),
      .next_box   (nxt_box[j]),
      .next_valid (nxt_valid[j]),
      .next_supp  (nxt_supp[j]),
      .head_box   (cell_box[0]),
      .head_area  (cell_area[0]),
      .nms_thr    (nms_overlap_threshold),
      .box        (cell_box[j]),
      .valid      (cell_valid[j]),
      .supp       (cell_supp[j]),
      .ge         (cell_ge[j]),
      .area       (cell_area[j])
    );
  end

  // head is last kept box when nothing live remains behind it
  assign final_box = !(|live);
  // insert only when the new score beats the tail or the chain has room
  assign do_insert = dec_keep && !cell_ge[N-1];

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbdn_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ctl         = '{op: dbdn_pkg::OP_HOLD, cmp_go: 1'b0};
    row_stall   = 1'b1;
    frame_clear = 1'b0;
    out_load    = 1'b0;
    out_status  = dbdn_pkg::STATUS_DET;
    out_final   = 1'b0;
    unique case (state)
      dbdn_pkg::ST_IDLE: begin
        row_stall = 1'b0;
        if (row_valid) begin
          state_next = dbdn_pkg::ST_DECODE;
          cnt_next   = '0;
        end
      end
      dbdn_pkg::ST_DECODE: begin
        cnt_next = cnt + 1'b1;
        if (cnt == dbdn_pkg::CNT_W'(dbdn_pkg::DEC_STAGES - 1)) state_next = dbdn_pkg::ST_INSERT;
      end
      dbdn_pkg::ST_INSERT: begin
        if (dec_keep) ctl.op = dbdn_pkg::OP_INSERT;
        state_next = last_r ? dbdn_pkg::ST_CHECK : dbdn_pkg::ST_IDLE;
      end
      dbdn_pkg::ST_CHECK: begin
        // count mismatch wins over an empty frame
        if (mismatch || cand_count == '0) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_final   = 1'b1;
            out_status  = mismatch ? dbdn_pkg::STATUS_MISMATCH : dbdn_pkg::STATUS_EMPTY;
            ctl.op      = dbdn_pkg::OP_CLEAR;
            frame_clear = 1'b1;
            state_next  = dbdn_pkg::ST_IDLE;
          end
        end else begin
          state_next = dbdn_pkg::ST_HEAD;
        end
      end
      dbdn_pkg::ST_HEAD: begin
        // suppressed heads just move out of the way
        if (cell_supp[0]) ctl.op = dbdn_pkg::OP_SHIFT;
        else state_next = dbdn_pkg::ST_CMP;
      end
      dbdn_pkg::ST_CMP: begin
        ctl.cmp_go = 1'b1;
        cnt_next   = '0;
        state_next = dbdn_pkg::ST_WAIT;
      end
      dbdn_pkg::ST_WAIT: begin
        cnt_next = cnt + 1'b1;
        if (cnt == dbdn_pkg::CNT_W'(dbdn_pkg::NMS_LAT - 1)) state_next = dbdn_pkg::ST_EMIT;
      end
      dbdn_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_final = final_box;
          if (final_box) begin
            ctl.op      = dbdn_pkg::OP_CLEAR;
            frame_clear = 1'b1;
            state_next  = dbdn_pkg::ST_IDLE;
          end else begin
            ctl.op     = dbdn_pkg::OP_SHIFT;
            state_next = dbdn_pkg::ST_HEAD;
          end
        end
      end
      default: state_next = dbdn_pkg::ST_IDLE;
    endcase
  end

  // frame walk and counters, advanced on each accepted request
  always_ff @(posedge clk) begin
    if (rst || frame_clear) begin
      level     <= 2'd0;
      cell_x    <= '0;
      cell_y    <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_count != dbdn_pkg::ROW_MAX) row_count <= row_count + 1'b1;
      if (level != 2'd3) begin
        if (dbdn_pkg::GRID_W'(cell_x) + 1'b1 >= gw) begin
          cell_x <= '0;
          if (dbdn_pkg::GRID_W'(cell_y) + 1'b1 >= gh) begin
            cell_y <= '0;
            level  <= level + 2'd1;
          end else begin
            cell_y <= cell_y + 1'b1;
          end
        end else begin
          cell_x <= cell_x + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) last_r <= last_row;
  end

  always_ff @(posedge clk) begin
    if (rst || frame_clear) cand_count <= '0;
    else if (state == dbdn_pkg::ST_INSERT && do_insert &&
             cand_count != dbdn_pkg::COUNT_W'(N))
      cand_count <= cand_count + 1'b1;
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) box_valid <= 1'b0;
    else if (out_load) box_valid <= 1'b1;
    else if (!box_stall) box_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      final_result <= out_final;
      status       <= out_status;
      if (out_status == dbdn_pkg::STATUS_DET) begin
        box_x1     <= cell_box[0].left;
        box_y1     <= cell_box[0].top;
        box_width  <= cell_box[0].right - cell_box[0].left;
        box_height <= cell_box[0].bottom - cell_box[0].top;
        box_score  <= cell_box[0].score;
      end else begin
        box_x1     <= '0;
        box_y1     <= '0;
        box_width  <= '0;
        box_height <= '0;
        box_score  <= '0;
      end
    end
  end

endmodule

[hdl/dbdn_checker.sv]
// port-level checks of the detection box decoder, bound to the top level
module dbdn_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            row_valid,
  input logic                            row_stall,
  input logic                            box_valid,
  input logic                            box_stall,
  input logic [15:0]                     box_x1,
  input logic [15:0]                     box_y1,
  input logic [15:0]                     box_width,
  input logic [15:0]                     box_height,
  input logic [15:0]                     box_score,
  input logic                            final_result,
  input logic [1:0]                      status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_stall |=> box_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_stall |=> $stable({box_x1, box_y1, box_width, box_height, box_score,
                                        final_result, status}))
    else $error("stalled result changed");

  a_flag_record: assert property (@(posedge clk) disable iff (rst)
    box_valid && status != 2'(dbdn_pkg::STATUS_DET) |->
      final_result && box_score == 16'd0 && box_width == 16'd0 && box_height == 16'd0)
    else $error("status record not final or not zero");

  a_box_size: assert property (@(posedge clk) disable iff (rst)
    box_valid && status == 2'(dbdn_pkg::STATUS_DET) |-> box_width != 16'd0 && box_height != 16'd0)
    else $error("detection with empty box");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall |=> row_stall)
    else $error("row taken while previous row still decoding");

endmodule

bind detection_box_decode_nms dbdn_checker u_dbdn_checker (.*);
